@@ rtl/lcs_pkg.sv @@
// lcs_pkg: shared constants and types for the line sensor centroid averager
// no dependencies; used by every module of the block but lcs_div
package lcs_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int SAMPLE_W      = 8;
  localparam int SUM_W         = 24;
  localparam int CNT_W         = 4;
  localparam int POS_W         = 16;
  localparam int WSUM_W        = 6;
  localparam int FIFO_DEPTH    = 2;
  localparam int OUT_DATA_W    = 24;

  localparam logic [SAMPLE_W-1:0] RESAMPLE_RESET = 8'd1;

  // one classified snapshot, handed from front end to back end
  typedef struct packed {
    logic signed [WSUM_W-1:0]   wsum2;
    logic        [CNT_W-1:0]    black_count;
    logic                       aligned;
    logic                       close;
    logic        [SAMPLE_W-1:0] taken;
  } item_t;

endpackage

@@ rtl/lcs_front.sv @@
// lcs_front: accepts snapshots, counts black sensors, forms the weight sum and
// tracks the averaging window; depends on lcs_pkg
module lcs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lcs_pkg::SAMPLE_W-1:0]      cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lcs_pkg::SAMPLE_W-1:0]      in_tdata,
  input  logic                              q_full,
  output logic                              q_push,
  output lcs_pkg::item_t                    q_item
);

  logic [lcs_pkg::SAMPLE_W-1:0] resample_r;
  logic [lcs_pkg::SAMPLE_W-1:0] taken_r;
  logic [lcs_pkg::SAMPLE_W-1:0] taken_nxt;
  logic [lcs_pkg::SAMPLE_W-1:0] limit;
  logic [lcs_pkg::SAMPLE_W:0]   taken_inc;
  logic signed [lcs_pkg::WSUM_W-1:0] wsum2;
  logic [lcs_pkg::CNT_W-1:0]    n;
  logic                         close;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // weight of sensor i doubled: 2i-7
  always_comb begin
    wsum2 = '0;
    n     = '0;
    for (int i = 0; i < lcs_pkg::SAMPLE_W; i++) begin
      if (in_tdata[i]) begin
        wsum2 = wsum2 + lcs_pkg::WSUM_W'(2 * i - 7);
        n     = n + lcs_pkg::CNT_W'(1);
      end
    end
  end

  assign limit     = (resample_r == '0) ? lcs_pkg::SAMPLE_W'(1) : resample_r;
  assign taken_inc = {1'b0, taken_r} + (lcs_pkg::SAMPLE_W+1)'(1);
  assign close     = taken_inc >= {1'b0, limit};
  assign taken_nxt = close ? '0 : taken_inc[lcs_pkg::SAMPLE_W-1:0];

  always_comb begin
    q_item.wsum2       = wsum2;
    q_item.black_count = n;
    q_item.aligned     = in_tdata[0] && in_tdata[lcs_pkg::SAMPLE_W-1];
    q_item.close       = close;
    q_item.taken       = taken_inc[lcs_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resample_r <= lcs_pkg::RESAMPLE_RESET;
      taken_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        resample_r <= cfg_wr_data;
      end
      if (q_push) begin
        taken_r <= taken_nxt;
      end
    end
  end

endmodule

@@ rtl/lcs_fifo.sv @@
// lcs_fifo: short register queue of classified snapshots between front and back
// depends on lcs_pkg (item type and depth)
module lcs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcs_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lcs_pkg::item_t pop_item
);

  localparam int AW = (lcs_pkg::FIFO_DEPTH > 1) ? $clog2(lcs_pkg::FIFO_DEPTH) : 1;

  lcs_pkg::item_t mem_r [lcs_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wptr_r;
  logic [AW-1:0]  rptr_r;
  logic [AW:0]    cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full      = cnt_r == (AW+1)'(lcs_pkg::FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(lcs_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(lcs_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/lcs_div.sv @@
// lcs_div: unsigned restoring divider, one quotient bit per cycle
// standalone; used by lcs_back for both the centroid and the window average
module lcs_div #(
  parameter int DW = 24,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= cnt_r != CW'(1);
    end
  end

endmodule

@@ rtl/lcs_back.sv @@
// lcs_back: per snapshot centroid divide, window accumulation, average divide
// and output register; depends on lcs_pkg and lcs_div
module lcs_back #(
  parameter int FRAC_BITS = lcs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_not_empty,
  input  lcs_pkg::item_t                     q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lcs_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int CW = FRAC_BITS + 3;
  localparam int DW = (lcs_pkg::SUM_W > FRAC_BITS + 5) ? lcs_pkg::SUM_W : FRAC_BITS + 5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CDIV = 4'b0010,
    S_ACC  = 4'b0100,
    S_ADIV = 4'b1000
  } state_t;

  state_t                              state_r;
  state_t                              state_nxt;
  logic signed [lcs_pkg::SUM_W-1:0]    sum_r;
  logic signed [lcs_pkg::SUM_W-1:0]    sum_nxt;
  logic signed [CW-1:0]                c_r;
  logic signed [CW-1:0]                c_nxt;
  logic [lcs_pkg::CNT_W-1:0]           n_r;
  logic                                aligned_r;
  logic                                close_r;
  logic [lcs_pkg::SAMPLE_W-1:0]        taken_r;
  logic                                neg_r;
  logic                                neg_nxt;
  logic                                ov_r;
  logic                                ov_nxt;
  logic [lcs_pkg::POS_W-1:0]           pos_r;
  logic [lcs_pkg::CNT_W-1:0]           ocnt_r;
  logic                                oal_r;
  logic                                out_load;

  logic                                div_start;
  logic [DW-1:0]                       div_dividend;
  logic [lcs_pkg::SAMPLE_W-1:0]        div_divisor;
  logic                                div_busy;
  logic [DW-1:0]                       div_quo;

  logic [lcs_pkg::WSUM_W-1:0]          wabs;
  logic [lcs_pkg::SAMPLE_W-1:0]        five_n;
  logic signed [lcs_pkg::SUM_W-1:0]    acc_sum;
  logic [lcs_pkg::SUM_W-1:0]           acc_abs;
  logic [CW-1:0]                       cq;
  logic [lcs_pkg::POS_W-1:0]           aq;

  lcs_div #(
    .DW (DW),
    .VW (lcs_pkg::SAMPLE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign wabs    = q_item.wsum2[lcs_pkg::WSUM_W-1] ? -q_item.wsum2 : q_item.wsum2;
  assign five_n  = ({4'd0, q_item.black_count} << 2) + {4'd0, q_item.black_count};
  assign acc_sum = sum_r + {{(lcs_pkg::SUM_W-CW){c_r[CW-1]}}, c_r};
  assign acc_abs = acc_sum[lcs_pkg::SUM_W-1] ? -acc_sum : acc_sum;
  assign cq      = div_quo[CW-1:0];
  assign aq      = div_quo[lcs_pkg::POS_W-1:0];
  assign out_load = (state_r == S_ADIV) && !div_busy && (!ov_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    c_nxt        = c_r;
    neg_nxt      = neg_r;
    ov_nxt       = ov_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop   = 1'b1;
          neg_nxt = q_item.wsum2[lcs_pkg::WSUM_W-1];
          if (q_item.black_count == '0) begin
            c_nxt     = '0;
            state_nxt = S_ACC;
          end else begin
            div_start    = 1'b1;
            div_dividend = DW'({{(DW-lcs_pkg::WSUM_W){1'b0}}, wabs} << FRAC_BITS);
            div_divisor  = five_n;
            state_nxt    = S_CDIV;
          end
        end
      end
      S_CDIV: begin
        if (!div_busy) begin
          c_nxt     = neg_r ? -cq : cq;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (close_r) begin
          div_start    = 1'b1;
          div_dividend = DW'(acc_abs);
          div_divisor  = taken_r;
          neg_nxt      = acc_sum[lcs_pkg::SUM_W-1];
          sum_nxt      = '0;
          state_nxt    = S_ADIV;
        end else begin
          sum_nxt   = acc_sum;
          state_nxt = S_IDLE;
        end
      end
      S_ADIV: begin
        if (out_load) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // latch the popped item's side fields, the centroid and its sign, and the output fields on a load
  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r       <= q_item.black_count;
      aligned_r <= q_item.aligned;
      close_r   <= q_item.close;
      taken_r   <= q_item.taken;
    end
    c_r   <= c_nxt;
    neg_r <= neg_nxt;
    if (out_load) begin
      pos_r  <= neg_r ? -aq : aq;
      ocnt_r <= n_r;
      oal_r  <= aligned_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, oal_r, ocnt_r, pos_r};

endmodule

@@ rtl/line_sensor_centroid_averager.sv @@
// line_sensor_centroid_averager: top level, front end, queue and back end
// depends on lcs_pkg, lcs_front, lcs_fifo, lcs_back (and lcs_div below it)
//
// Usage:
//   in_*  : one 8-bit sensor snapshot per transaction (bit i = sensor i black).
//   out_* : one result per closed window: averaged position (signed Q1.FRAC_BITS),
//           black count and aligned flag of the window's last snapshot.
//   cfg_* : cfg_wr_en writes resample_count (snapshots per window, 0 acts as 1).
// The back end runs a snapshot with a black sensor through the centroid divide
//   and then the accumulate step, and one with no black sensor through the
//   accumulate step alone; a snapshot that closes a window then adds the average
//   divide. Both divides share one bit-serial divider, one quotient bit per
//   cycle, so the back end finishes one snapshot before it takes the next.
// With the back end idle, out_tvalid rises from the output register once the
//   closing snapshot has passed these steps.
// A two-entry queue sits between front and back, so in_tready stays high while
//   the back end works until the queue fills.
// Reset (rst_n, synchronous) clears the window sum and count, empties the queue
//   and sets resample_count to 1. When out_tready is low the result waits in the
//   output register; the back end keeps working until it needs that register.
module line_sensor_centroid_averager #(
  parameter int FRAC_BITS = lcs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lcs_pkg::SAMPLE_W-1:0]       cfg_wr_data,   // resample_count
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lcs_pkg::SAMPLE_W-1:0]       in_tdata,      // [7:0] sample_bits
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] position_avg, [19:16] black_count, [20] aligned, [23:21] zero
  output logic [lcs_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;
  lcs_pkg::item_t q_in_item;
  lcs_pkg::item_t q_out_item;

  lcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  lcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out_item)
  );

  lcs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_out_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ bench/line_sensor_centroid_averager_test.sv @@
// line_sensor_centroid_averager_test: self-checking bench for the centroid averager
// depends on lcs_pkg and the line_sensor_centroid_averager rtl; predicts each window
// average from the accepted snapshots and checks every result transaction against it
`timescale 1ns / 100ps

module line_sensor_centroid_averager_test;

  localparam int FRAC         = lcs_pkg::FRAC_BITS_DEF;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_CYCLES  = 400;
  // queued snapshots plus the two divides of a closing one
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 110;

  typedef struct packed {
    logic signed [lcs_pkg::POS_W-1:0] position;
    logic        [lcs_pkg::CNT_W-1:0] black_count;
    logic                             aligned;
  } position_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [lcs_pkg::SAMPLE_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lcs_pkg::SAMPLE_W-1:0] in_tdata = '0;   // [7:0] sample_bits
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [15:0] position_avg, [19:16] black_count, [20] aligned
  logic [lcs_pkg::OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic [lcs_pkg::SAMPLE_W-1:0]      window_len = lcs_pkg::RESAMPLE_RESET;
  logic signed [lcs_pkg::SUM_W-1:0]  centroid_acc = '0;
  logic [lcs_pkg::SAMPLE_W-1:0]      window_fill = '0;
  position_result_t                  position_results_q[$];

  int failures = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  always #6 clk = ~clk;

  line_sensor_centroid_averager uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // fold one accepted snapshot into the window, queue a result when it closes
  task automatic track_sample(input logic [7:0] bits);
    int wsum;
    int cnt;
    int cent;
    int total;
    int taken;
    int limit;
    position_result_t r;
    wsum = 0;
    cnt = 0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        wsum += 2 * i - 7;
        cnt++;
      end
    end
    cent = (cnt == 0) ? 0 : (wsum * (1 << FRAC)) / (5 * cnt);
    centroid_acc = centroid_acc + cent[lcs_pkg::SUM_W-1:0];
    limit = (window_len == 0) ? 1 : int'(window_len);
    taken = int'(window_fill) + 1;
    if (taken < limit) begin
      window_fill = taken[7:0];
    end else begin
      total = centroid_acc;
      total = total / taken;
      r.position = total[lcs_pkg::POS_W-1:0];
      r.black_count = cnt[lcs_pkg::CNT_W-1:0];
      r.aligned = bits[0] & bits[7];
      position_results_q.push_back(r);
      centroid_acc = '0;
      window_fill = '0;
    end
  endtask

  task automatic send_sample(input logic [7:0] bits);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= bits;
    do @(posedge clk); while (!in_tready);
    track_sample(bits);
  endtask

  // wait for all results, then let snapshots that close nothing drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (position_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [7:0] len);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_len = len;
  endtask

  function automatic logic [7:0] draw_sample();
    int unsigned pick;
    int unsigned width;
    int unsigned pos;
    logic [7:0] bar;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 8'($urandom);
    if (pick < 8) begin
      // a line under one to three neighboring sensors
      width = $urandom_range(1, 3);
      pos = $urandom_range(0, 8 - width);
      bar = ((8'd1 << width) - 8'd1) << pos;
      return bar;
    end
    if (pick == 8) return 8'h00;
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h81;
  endfunction

  task automatic test_single_snapshots();
    logic [7:0] pattern[$];
    pattern = '{8'h00, 8'hFF, 8'h81, 8'h01, 8'h80, 8'h02, 8'h04, 8'h08,
                8'h10, 8'h20, 8'h40, 8'h7F, 8'hFE, 8'h18, 8'hC3};
    set_window(8'd1);
    foreach (pattern[i]) send_sample(pattern[i]);
  endtask

  // a window length of zero behaves as one
  task automatic test_zero_window();
    set_window(8'd0);
    send_sample(8'h01);
    send_sample(8'h3C);
  endtask

  task automatic test_short_window();
    set_window(8'd3);
    send_sample(8'h01);
    send_sample(8'h80);
    send_sample(8'h06);
    // grow the window, then shrink it below the snapshots already summed
    set_window(8'd5);
    send_sample(8'h01);
    send_sample(8'h03);
    send_sample(8'h81);
    set_window(8'd2);
    send_sample(8'h80);
  endtask

  task automatic test_backpressure();
    set_window(8'd1);
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_sample(draw_sample());
    idle_on = 1'b1;
  endtask

  task automatic test_long_window();
    set_window(8'd255);
    repeat (255) send_sample(($urandom_range(0, 7) != 0) ? 8'h01 : draw_sample());
  endtask

  task automatic test_random_windows();
    int unsigned pick;
    logic [7:0] len;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: len = 8'd1;
        1: len = 8'd2;
        2: len = 8'd3;
        3: len = 8'd4;
        4: len = 8'd8;
        5: len = 8'd0;
        default: len = 8'($urandom_range(1, 20));
      endcase
      set_window(len);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_sample(draw_sample());
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    position_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (position_results_q.size() == 0) begin
        $error("result transaction with none expected: data %h", out_tdata);
        failures++;
      end else begin
        want = position_results_q.pop_front();
        if (out_tdata[15:0] !== want.position) begin
          $error("position_avg: expected %0d, got %0d",
                 want.position, $signed(out_tdata[15:0]));
          failures++;
        end
        if (out_tdata[19:16] !== want.black_count) begin
          $error("black_count: expected %0d, got %0d", want.black_count, out_tdata[19:16]);
          failures++;
        end
        if (out_tdata[20] !== want.aligned) begin
          $error("aligned: expected %0d, got %0d", want.aligned, out_tdata[20]);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("line_sensor_centroid_averager_test: FAIL");
    $finish;
  end

  initial begin : sequencer
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_single_snapshots();
    test_zero_window();
    test_short_window();
    test_backpressure();
    test_long_window();
    test_random_windows();
    wait_idle();
    if (failures == 0) begin
      $display("line_sensor_centroid_averager_test: PASS");
    end else begin
      $display("line_sensor_centroid_averager_test: FAIL");
    end
    $finish;
  end

endmodule
